/* rtl/dots_pkg.sv */
// ----------------------------------------------------------------------------
// dots_pkg
// shared types and constants of the dhcp option scanner
// ----------------------------------------------------------------------------
package dots_pkg;

    localparam int HEADER_BYTES = 236;   // fixed header before the options area
    localparam int OPTION_BYTES = 312;   // options area size, below 512
    localparam int COOKIE_BYTES = 4;
    localparam int POS_W        = 9;

    localparam logic [7:0] END_CODE = 8'hFF;
    localparam logic [7:0] PAD_CODE = 8'h00;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  opt_byte;
        logic [7:0]  wanted_code;
        logic [15:0] udp_len;
    } dots_in_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] offset;
        logic [7:0]       opt_len;
    } dots_res_t;

    typedef enum logic [3:0] {
        PH_COOKIE = 4'b0001,
        PH_CODE   = 4'b0010,
        PH_LEN    = 4'b0100,
        PH_SKIP   = 4'b1000
    } dots_phase_t;

endpackage

/* rtl/dots_in_if.sv */
// ----------------------------------------------------------------------------
// dots_in_if
// command channel: start items and options bytes
// ----------------------------------------------------------------------------
interface dots_in_if import dots_pkg::*; ();
    logic     valid;
    logic     ready;
    dots_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/dots_out_if.sv */
// ----------------------------------------------------------------------------
// dots_out_if
// result channel: one item per scanned message
// ----------------------------------------------------------------------------
interface dots_out_if import dots_pkg::*; ();
    logic      valid;
    logic      ready;
    dots_res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/dhcp_option_tlv_scanner_core.sv */
// ----------------------------------------------------------------------------
// dhcp_option_tlv_scanner_core
// scans a dhcp options area byte by byte for a wanted option code
// ----------------------------------------------------------------------------
// path: an accepted item is held in the input register, and its result is then
//   loaded into the result register
// throughput: one item per cycle; an item that gives a result waits in the
//   input register while the result register is full and not being taken
// reset: asynchronous, active low; clears the scan state to idle and empties
//   both the input register and the result register
module dhcp_option_tlv_scanner_core import dots_pkg::*; #(
    parameter int HDR_BYTES = HEADER_BYTES,
    parameter int OPT_BYTES = OPTION_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    dots_in_if.sink     cmd,
    dots_out_if.source  res
);

    // input stage
    logic        in_vld_reg;
    dots_in_t    in_reg;

    // scan state
    logic             active_reg,  active_next;
    dots_phase_t      phase_reg,   phase_next;
    logic [POS_W-1:0] pos_reg,     pos_next;
    logic [POS_W-1:0] lim_reg,     lim_next;
    logic [7:0]       skip_reg,    skip_next;
    logic [7:0]       code_reg,    code_next;
    logic [7:0]       target_reg,  target_next;

    // result stage
    logic        res_vld_reg;
    dots_res_t   res_reg;

    // combinational work on the registered item
    logic             emit;
    dots_res_t        emit_res;
    logic             adv;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W:0]   len_end;
    logic [15:0]      lim_raw;
    logic [POS_W-1:0] lim_cap;
    logic             short_pl;
    logic [7:0]       skip_dec;

    assign pos_inc  = pos_reg + POS_W'(1);
    assign len_end  = {1'b0, pos_inc} + (POS_W+1)'(in_reg.opt_byte);
    assign skip_dec = skip_reg - 8'd1;

    // payload shorter than header plus cookie gives no scan
    assign short_pl = {1'b0, in_reg.udp_len} < 17'(HDR_BYTES + COOKIE_BYTES);
    assign lim_raw  = in_reg.udp_len - 16'(HDR_BYTES);
    assign lim_cap  = (lim_raw > 16'(OPT_BYTES)) ? POS_W'(OPT_BYTES)
                                                 : lim_raw[POS_W-1:0];

    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        lim_next    = lim_reg;
        skip_next   = skip_reg;
        code_next   = code_reg;
        target_next = target_reg;
        emit        = 1'b0;
        emit_res    = '0;

        if (in_reg.command == CMD_START)
        begin
            // a new start drops any running scan silently
            pos_next    = '0;
            phase_next  = PH_COOKIE;
            skip_next   = '0;
            code_next   = '0;
            target_next = in_reg.wanted_code;
            if (short_pl)
            begin
                lim_next    = '0;
                active_next = 1'b0;
                emit        = 1'b1;
            end
            else
            begin
                lim_next    = lim_cap;
                active_next = 1'b1;
                // options area holds only the cookie
                if (lim_cap <= POS_W'(COOKIE_BYTES))
                begin
                    active_next = 1'b0;
                    emit        = 1'b1;
                end
            end
        end
        else if (active_reg)
        begin
            pos_next = pos_inc;
            case (phase_reg)
                PH_COOKIE:
                begin
                    if (pos_inc >= POS_W'(COOKIE_BYTES))
                        phase_next = PH_CODE;
                end
                PH_CODE:
                begin
                    if (in_reg.opt_byte == END_CODE)
                        emit = 1'b1;
                    else if (in_reg.opt_byte != PAD_CODE)
                    begin
                        code_next  = in_reg.opt_byte;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    // option running past the limit ends the scan
                    if (len_end > {1'b0, lim_reg})
                        emit = 1'b1;
                    else if (code_reg == target_reg)
                    begin
                        emit             = 1'b1;
                        emit_res.found   = 1'b1;
                        emit_res.offset  = pos_inc - POS_W'(2);
                        emit_res.opt_len = in_reg.opt_byte;
                    end
                    else if (in_reg.opt_byte == 8'd0)
                        phase_next = PH_CODE;
                    else
                    begin
                        skip_next  = in_reg.opt_byte;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 8'd0)
                        phase_next = PH_CODE;
                end
                default:
                begin
                    phase_next = PH_CODE;
                end
            endcase
            // limit reached without a match
            if (!emit && (pos_inc >= lim_reg))
                emit = 1'b1;
            if (emit)
                active_next = 1'b0;
        end
    end

    // the registered item moves on unless its result would hit a full output
    assign adv       = in_vld_reg && (!res_vld_reg || res.ready || !emit);
    assign cmd.ready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (cmd.ready)
            in_vld_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
            in_reg <= cmd.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= PH_COOKIE;
            pos_reg    <= '0;
            lim_reg    <= '0;
            skip_reg   <= '0;
            code_reg   <= '0;
            target_reg <= '0;
        end
        else if (adv)
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            lim_reg    <= lim_next;
            skip_reg   <= skip_next;
            code_reg   <= code_next;
            target_reg <= target_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (adv && emit)
            res_vld_reg <= 1'b1;
        else if (res.ready)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
            res_reg <= emit_res;
    end

    assign res.valid = res_vld_reg;
    assign res.data  = res_reg;

    // bytes outside a scan never give a result
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && in_reg.command == CMD_BYTE && !active_reg) |-> !emit)
        else $error("result from an options byte outside a scan");

    // every result closes the scan
    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && emit) |=> !active_reg)
        else $error("scan still running after its result");

    // a running scan stays below its limit
    a_pos_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (pos_reg < lim_reg))
        else $error("scan position at or past the limit");

    // skipping always has data bytes left
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && phase_reg == PH_SKIP) |-> (skip_reg != 8'd0))
        else $error("skip phase with nothing left to skip");

    // a match can only sit after the cookie
    a_hit_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && res_reg.found) |-> (res_reg.offset >= POS_W'(COOKIE_BYTES)))
        else $error("match reported inside the cookie");

endmodule
